FILE: rtl/nnp_pkg.sv
// ---------------------------------------------------------------------------
// nnp_pkg: note name parser shared definitions
// Widths, limits, character codes, status codes and the letter decode used
// by the parse front end and the pitch arithmetic pipeline.
// ---------------------------------------------------------------------------
package nnp_pkg;

    // field widths fixed by the interface
    localparam int CHAR_W   = 8;
    localparam int PITCH_W  = 22;
    localparam int STATUS_W = 3;

    // parse limits
    localparam int OCTAVE_MAX     = 999;
    localparam int CENTS_MAX      = 9999;
    localparam int ACCIDENTAL_MAX = 15;
    localparam int PITCH_LIMIT    = 1300000;

    // derived widths of the parse state
    localparam int OCT_W       = $clog2(OCTAVE_MAX + 1);
    localparam int OCT_DIG_W   = OCT_W + 4;
    localparam int CENTS_W     = $clog2(CENTS_MAX + 1);
    localparam int CENTS_DIG_W = CENTS_W + 4;
    localparam int ACC_W       = $clog2(ACCIDENTAL_MAX + 2) + 1;
    localparam int CLS_W       = ACC_W + 2;

    // derived widths of the pitch arithmetic
    localparam int SEMI_W = OCT_W + 6;
    localparam int V_MAX  = (OCTAVE_MAX + 2) * 1200 + CENTS_MAX + 100 * (ACCIDENTAL_MAX + 12);
    localparam int V_W    = $clog2(V_MAX) + 2;
    localparam int MAG_W  = V_W - 1;

    // reciprocal of 100, exact floor for every magnitude below 2^MAG_W
    localparam int     RCP_SHIFT = MAG_W + 7;
    localparam int     RCP_W     = RCP_SHIFT - 6;
    localparam longint RCP_MUL   = ((64'd1 << RCP_SHIFT) + 64'd99) / 64'd100;
    localparam int     PROD_W    = MAG_W + RCP_W;
    localparam int     Q_W       = MAG_W - 6;

    localparam logic signed [ACC_W-1:0] ACC_LIMIT = ACC_W'(ACCIDENTAL_MAX);

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LETTER   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNPARSED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SHARP      = 8'h23;
    localparam logic [CHAR_W-1:0] CH_FLAT       = 8'h62;
    localparam logic [CHAR_W-1:0] CH_BANG       = 8'h21;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UTF8_LEAD  = 8'hE2;
    localparam logic [CHAR_W-1:0] CH_UTF8_MID   = 8'h99;
    localparam logic [CHAR_W-1:0] CH_UTF8_SHARP = 8'hAF;
    localparam logic [CHAR_W-1:0] CH_UTF8_FLAT  = 8'hAD;
    localparam logic [CHAR_W-1:0] CH_CASE_BIT   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LOW_A      = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_B      = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LOW_C      = 8'h63;
    localparam logic [CHAR_W-1:0] CH_LOW_D      = 8'h64;
    localparam logic [CHAR_W-1:0] CH_LOW_E      = 8'h65;
    localparam logic [CHAR_W-1:0] CH_LOW_F      = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LOW_G      = 8'h67;

    typedef enum logic [2:0] {
        PH_LETTER,
        PH_ACC,
        PH_OCT,
        PH_CENTS,
        PH_SINK
    } phase_t;

    // parsed note handed from the front end to the arithmetic pipeline
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [OCT_W:0]     octave;
        logic signed [CLS_W-1:0]   cls;
        logic signed [CENTS_W:0]   cents;
    } note_fields_t;

    // letter decode: bit 4 set when the byte is a note letter, low bits the class
    function automatic logic [4:0] letter_class(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] low;
        logic [4:0]        res;
        low = c | CH_CASE_BIT;
        unique case (low)
            CH_LOW_C: res = {1'b1, 4'd0};
            CH_LOW_D: res = {1'b1, 4'd2};
            CH_LOW_E: res = {1'b1, 4'd4};
            CH_LOW_F: res = {1'b1, 4'd5};
            CH_LOW_G: res = {1'b1, 4'd7};
            CH_LOW_A: res = {1'b1, 4'd9};
            CH_LOW_B: res = {1'b1, 4'd11};
            default:  res = 5'd0;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/nnp_parse.sv
// ---------------------------------------------------------------------------
// nnp_parse: note string front end
// Holds the parse state, takes one byte per accepted word and presents the
// parsed note fields for the end marker.
// ---------------------------------------------------------------------------
module nnp_parse (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [nnp_pkg::CHAR_W-1:0] character,
    input  logic                       is_end,
    output nnp_pkg::note_fields_t      fields
);
    import nnp_pkg::*;

    phase_t                    phase_reg,  phase_next;
    logic [3:0]                class_reg,  class_next;
    logic signed [ACC_W-1:0]   acc_reg,    acc_next;
    logic [1:0]                utf8_reg,   utf8_next;
    logic [OCT_W-1:0]          oct_reg,    oct_next;
    logic                      oct_neg_reg, oct_neg_next;
    logic [CENTS_W-1:0]        cents_reg,  cents_next;
    logic                      cents_neg_reg, cents_neg_next;
    logic [STATUS_W-1:0]       err_reg,    err_next;

    logic [4:0]                letter;
    logic                      is_digit;
    logic [3:0]                digit;
    logic [OCT_DIG_W-1:0]      oct_ext, oct_dig;
    logic [CENTS_DIG_W-1:0]    cents_ext, cents_dig;
    logic                      oct_over, cents_over;
    logic signed [ACC_W-1:0]   acc_inc, acc_dec;
    logic                      inc_over, dec_over;

    // byte classification and digit accumulation
    always_comb
    begin
        letter    = letter_class(character);
        is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
        digit     = 4'(character - CH_ZERO);
        oct_ext   = OCT_DIG_W'(oct_reg);
        oct_dig   = (oct_ext << 3) + (oct_ext << 1) + OCT_DIG_W'(digit);
        oct_over  = oct_dig > OCT_DIG_W'(OCTAVE_MAX);
        cents_ext = CENTS_DIG_W'(cents_reg);
        cents_dig = (cents_ext << 3) + (cents_ext << 1) + CENTS_DIG_W'(digit);
        cents_over = cents_dig > CENTS_DIG_W'(CENTS_MAX);
        acc_inc   = acc_reg + ACC_W'(1);
        acc_dec   = acc_reg - ACC_W'(1);
        inc_over  = acc_inc > ACC_LIMIT;
        dec_over  = acc_dec < -ACC_LIMIT;
    end

    // parse state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LETTER;
            class_reg     <= '0;
            acc_reg       <= '0;
            utf8_reg      <= '0;
            oct_reg       <= '0;
            oct_neg_reg   <= 1'b0;
            cents_reg     <= '0;
            cents_neg_reg <= 1'b0;
            err_reg       <= ST_OK;
        end
        else
        begin
            phase_reg     <= phase_next;
            class_reg     <= class_next;
            acc_reg       <= acc_next;
            utf8_reg      <= utf8_next;
            oct_reg       <= oct_next;
            oct_neg_reg   <= oct_neg_next;
            cents_reg     <= cents_next;
            cents_neg_reg <= cents_neg_next;
            err_reg       <= err_next;
        end
    end

    // next parse state; a failure records its code and parks in the sink
    always_comb
    begin
        phase_next     = phase_reg;
        class_next     = class_reg;
        acc_next       = acc_reg;
        utf8_next      = utf8_reg;
        oct_next       = oct_reg;
        oct_neg_next   = oct_neg_reg;
        cents_next     = cents_reg;
        cents_neg_next = cents_neg_reg;
        err_next       = err_reg;
        if (accept && is_end)
        begin
            phase_next     = PH_LETTER;
            class_next     = '0;
            acc_next       = '0;
            utf8_next      = '0;
            oct_next       = '0;
            oct_neg_next   = 1'b0;
            cents_next     = '0;
            cents_neg_next = 1'b0;
            err_next       = ST_OK;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_LETTER:
                begin
                    if (letter[4])
                    begin
                        class_next = letter[3:0];
                        phase_next = PH_ACC;
                    end
                    else
                    begin
                        phase_next = PH_SINK;
                        err_next   = ST_LETTER;
                    end
                end
                PH_ACC:
                begin
                    if (utf8_reg == 2'd1)
                    begin
                        if (character == CH_UTF8_MID)
                            utf8_next = 2'd2;
                        else
                        begin
                            phase_next = PH_SINK;
                            err_next   = ST_UNPARSED;
                        end
                    end
                    else if (utf8_reg == 2'd2)
                    begin
                        utf8_next = 2'd0;
                        if (character == CH_UTF8_SHARP)
                        begin
                            acc_next = acc_inc;
                            if (inc_over)
                            begin
                                phase_next = PH_SINK;
                                err_next   = ST_RANGE;
                            end
                        end
                        else if (character == CH_UTF8_FLAT)
                        begin
                            acc_next = acc_dec;
                            if (dec_over)
                            begin
                                phase_next = PH_SINK;
                                err_next   = ST_RANGE;
                            end
                        end
                        else
                        begin
                            phase_next = PH_SINK;
                            err_next   = ST_UNPARSED;
                        end
                    end
                    else if (character == CH_SHARP)
                    begin
                        acc_next = acc_inc;
                        if (inc_over)
                        begin
                            phase_next = PH_SINK;
                            err_next   = ST_RANGE;
                        end
                    end
                    else if (character == CH_FLAT || character == CH_BANG)
                    begin
                        acc_next = acc_dec;
                        if (dec_over)
                        begin
                            phase_next = PH_SINK;
                            err_next   = ST_RANGE;
                        end
                    end
                    else if (character == CH_UTF8_LEAD)
                        utf8_next = 2'd1;
                    else if (character == CH_MINUS)
                    begin
                        oct_neg_next = 1'b1;
                        phase_next   = PH_OCT;
                    end
                    else if (is_digit)
                    begin
                        if (oct_over)
                        begin
                            phase_next = PH_SINK;
                            err_next   = ST_RANGE;
                        end
                        else
                        begin
                            phase_next = PH_OCT;
                            oct_next   = oct_dig[OCT_W-1:0];
                        end
                    end
                    else if (character == CH_PLUS)
                        phase_next = PH_CENTS;
                    else
                    begin
                        phase_next = PH_SINK;
                        err_next   = ST_UNPARSED;
                    end
                end
                PH_OCT:
                begin
                    if (is_digit)
                    begin
                        if (oct_over)
                        begin
                            phase_next = PH_SINK;
                            err_next   = ST_RANGE;
                        end
                        else
                            oct_next = oct_dig[OCT_W-1:0];
                    end
                    else if (character == CH_PLUS)
                        phase_next = PH_CENTS;
                    else if (character == CH_MINUS)
                    begin
                        cents_neg_next = 1'b1;
                        phase_next     = PH_CENTS;
                    end
                    else
                    begin
                        phase_next = PH_SINK;
                        err_next   = ST_UNPARSED;
                    end
                end
                PH_CENTS:
                begin
                    if (is_digit && !cents_over)
                        cents_next = cents_dig[CENTS_W-1:0];
                    else if (is_digit)
                    begin
                        phase_next = PH_SINK;
                        err_next   = ST_RANGE;
                    end
                    else
                    begin
                        phase_next = PH_SINK;
                        err_next   = ST_UNPARSED;
                    end
                end
                PH_SINK:
                begin
                    phase_next = PH_SINK;
                end
                default:
                begin
                    phase_next = PH_SINK;
                end
            endcase
        end
    end

    // note fields as seen by an end marker in this cycle
    always_comb
    begin
        if (phase_reg == PH_LETTER)
            fields.status = ST_EMPTY;
        else if (phase_reg == PH_ACC && utf8_reg != 2'd0)
            fields.status = ST_UNPARSED;
        else
            fields.status = err_reg;
        fields.octave = oct_neg_reg ? -$signed({1'b0, oct_reg}) : $signed({1'b0, oct_reg});
        fields.cls    = CLS_W'($signed({1'b0, class_reg})) + CLS_W'(acc_reg);
        fields.cents  = cents_neg_reg ? -$signed({1'b0, cents_reg})
                                      : $signed({1'b0, cents_reg});
    end

    // an end marker always leaves a clean parse state behind
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_end |=> phase_reg == PH_LETTER && err_reg == ST_OK && acc_reg == '0)
        else $error("parse state not cleared after end marker");

    // an error code is only held while parked in the sink
    a_err_sink: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_SINK |-> err_reg == ST_OK)
        else $error("error recorded outside the sink phase");

    // a multibyte accidental is in flight in the accidental phase, or was cut off into the sink
    a_utf8_phase: assert property (@(posedge clk) disable iff (!rst_n)
        utf8_reg != 2'd0 |-> phase_reg == PH_ACC || phase_reg == PH_SINK)
        else $error("utf8 progress outside accidental phase");

endmodule

FILE: rtl/nnp_calc.sv
// ---------------------------------------------------------------------------
// nnp_calc: pitch arithmetic pipeline
// Turns parsed note fields into hundredths of a semitone with optional
// rounding and a range check, through elastic stages and an output register.
// ---------------------------------------------------------------------------
module nnp_calc (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                round_to_semitone,
    input  logic                                load_valid,
    input  nnp_pkg::note_fields_t               fields,
    output logic                                load_ready,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [nnp_pkg::PITCH_W-1:0]  pitch_hundredths,
    output logic [nnp_pkg::STATUS_W-1:0]        status
);
    import nnp_pkg::*;

    localparam logic [RCP_W-1:0] RCP_C = RCP_W'(RCP_MUL);

    // stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

    // stage payloads
    note_fields_t               f1_reg;
    logic [STATUS_W-1:0]        st2_reg, st3_reg, st4_reg, st5_reg;
    logic signed [SEMI_W-1:0]   semi2_reg;
    logic signed [CENTS_W:0]    cents2_reg;
    logic signed [V_W-1:0]      v3_val_reg;
    logic                       neg4_reg, neg5_reg;
    logic [MAG_W-1:0]           mag4_reg, mag5_reg, magp4_reg;
    logic [PROD_W-1:0]          prod5_reg;
    logic signed [PITCH_W-1:0]  pitch_reg;
    logic [STATUS_W-1:0]        status_reg;

    // combinational next values
    logic signed [SEMI_W-1:0]   oct_p1, semi_next;
    logic signed [V_W-1:0]      semi_w, v_next;
    logic [MAG_W-1:0]           mag_next, magp_next;
    logic [PROD_W-1:0]          prod_next;
    logic [Q_W-1:0]             quot;
    logic [MAG_W-1:0]           rmag, sel_mag;
    logic                       over;
    logic signed [MAG_W:0]      signed_mag;
    logic [STATUS_W-1:0]        status_next;
    logic signed [PITCH_W-1:0]  pitch_next;

    // a stage takes new data when it is empty or its contents move on
    always_comb
    begin
        rdy_out    = !out_valid_reg || !result_stall;
        rdy5       = !v5_reg || rdy_out;
        rdy4       = !v4_reg || rdy5;
        rdy3       = !v3_reg || rdy4;
        rdy2       = !v2_reg || rdy3;
        rdy1       = !v1_reg || rdy2;
        load_ready = rdy1;
    end

    // semitone count: (octave + 1) * 12 + class
    always_comb
    begin
        oct_p1    = SEMI_W'(f1_reg.octave) + SEMI_W'(1);
        semi_next = (oct_p1 <<< 3) + (oct_p1 <<< 2) + SEMI_W'(f1_reg.cls);
    end

    // hundredths: semitones * 100 + cents
    always_comb
    begin
        semi_w = V_W'(semi2_reg);
        v_next = (semi_w <<< 6) + (semi_w <<< 5) + (semi_w <<< 2) + V_W'(cents2_reg);
    end

    // magnitude and half-step bias for rounding
    always_comb
    begin
        mag_next  = v3_val_reg[V_W-1] ? MAG_W'(-v3_val_reg) : MAG_W'(v3_val_reg);
        magp_next = mag_next + MAG_W'(50);
    end

    // reciprocal multiply for the divide by 100
    assign prod_next = PROD_W'(magp4_reg) * PROD_W'(RCP_C);

    // rounding select, range check and sign
    always_comb
    begin
        quot       = prod5_reg[RCP_SHIFT +: Q_W];
        rmag       = MAG_W'({quot, 6'b0}) + MAG_W'({quot, 5'b0}) + MAG_W'({quot, 2'b0});
        sel_mag    = round_to_semitone ? rmag : mag5_reg;
        over       = 32'(sel_mag) > 32'(PITCH_LIMIT);
        signed_mag = neg5_reg ? -$signed({1'b0, sel_mag}) : $signed({1'b0, sel_mag});
        if (st5_reg != ST_OK)
            status_next = st5_reg;
        else if (over)
            status_next = ST_RANGE;
        else
            status_next = ST_OK;
        pitch_next = (status_next == ST_OK) ? PITCH_W'(signed_mag) : '0;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= load_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy5)
                v5_reg <= v4_reg;
            if (rdy_out)
                out_valid_reg <= v5_reg;
        end
    end

    // stage payload registers; cents travel alongside the semitone stage
    always_ff @(posedge clk)
    begin
        if (rdy1)
            f1_reg <= fields;
        if (rdy2)
        begin
            st2_reg    <= f1_reg.status;
            semi2_reg  <= semi_next;
            cents2_reg <= f1_reg.cents;
        end
        if (rdy3)
        begin
            st3_reg    <= st2_reg;
            v3_val_reg <= v_next;
        end
        if (rdy4)
        begin
            st4_reg   <= st3_reg;
            neg4_reg  <= v3_val_reg[V_W-1];
            mag4_reg  <= mag_next;
            magp4_reg <= magp_next;
        end
        if (rdy5)
        begin
            st5_reg   <= st4_reg;
            neg5_reg  <= neg4_reg;
            mag5_reg  <= mag4_reg;
            prod5_reg <= prod_next;
        end
        if (rdy_out)
        begin
            pitch_reg  <= pitch_next;
            status_reg <= status_next;
        end
    end

    assign result_valid     = out_valid_reg;
    assign pitch_hundredths = pitch_reg;
    assign status           = status_reg;

    // an error result carries a zero pitch
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_OK |-> pitch_hundredths == '0)
        else $error("nonzero pitch with error status");

    // a good result is inside the pitch range
    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_OK |->
            pitch_hundredths <= PITCH_LIMIT && pitch_hundredths >= -PITCH_LIMIT)
        else $error("good result outside pitch range");

    // a full pipe under a stalled output refuses new words
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && out_valid_reg && result_stall
            |-> !load_ready)
        else $error("pipeline accepted a word while full");

endmodule

FILE: rtl/note_name_to_pitch_parser_core.sv
// An end marker, once accepted, loads the first stage of the five-stage arithmetic
// pipe and moves through the later stages and the output register before
// result_valid rises. Throughput: one word (byte or end marker) per cycle; the parse
// state loop updates on each accepted word. Input stalls only when every arithmetic
// stage and the output register hold results waiting on a stalled output.
// Reset clears the parse state, the pipeline valids and round_to_semitone.
// ---------------------------------------------------------------------------
// note_name_to_pitch_parser_core: note name to pitch parser
// Parses a note string byte by byte and returns the pitch in hundredths of a
// semitone, or an error status, for each end marker.
// ---------------------------------------------------------------------------
module note_name_to_pitch_parser_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [nnp_pkg::CHAR_W-1:0]          character,
    input  logic                                is_end,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [nnp_pkg::PITCH_W-1:0]  pitch_hundredths,
    output logic [nnp_pkg::STATUS_W-1:0]        status
);
    import nnp_pkg::*;

    logic          round_reg;
    logic          accept;
    logic          load_ready;
    note_fields_t  fields;

    // rounding mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            round_reg <= 1'b0;
        else if (cfg_wr_en)
            round_reg <= cfg_wr_data;
    end

    // input word handshake
    assign item_stall = !load_ready;
    assign accept     = item_valid && load_ready;

    // parse front end
    nnp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .character (character),
        .is_end    (is_end),
        .fields    (fields)
    );

    // pitch arithmetic pipeline
    nnp_calc u_calc (
        .clk               (clk),
        .rst_n             (rst_n),
        .round_to_semitone (round_reg),
        .load_valid        (accept && is_end),
        .fields            (fields),
        .load_ready        (load_ready),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .pitch_hundredths  (pitch_hundredths),
        .status            (status)
    );

endmodule
